// ===== rtl/pcsd_pkg.sv =====
// shared widths and stage payload type for the pixel channel spread pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package pcsd_pkg;

	localparam int unsigned CHAN_W  = 8;   // one colour channel
	localparam int unsigned DIFF_W  = 11;  // signed b+c-2a, range -510..510
	localparam int unsigned MAG_W   = 9;   // magnitude of a difference, 0..510
	localparam int unsigned SQ_W    = 2 * MAG_W;
	localparam int unsigned SUM_W   = SQ_W + 2;
	localparam int unsigned Q_W     = 19;  // Q stays at or below 390150
	localparam int unsigned Q4_W    = Q_W + 2;
	localparam int unsigned ROOT_W  = 7;   // spread, search range 0..127
	localparam int unsigned ODD_W   = ROOT_W + 1;
	localparam int unsigned ODDSQ_W = 2 * ODD_W;

	// payload handed from one root cell to the next
	typedef struct packed {
		logic [Q4_W-1:0]   q4;
		logic [ROOT_W-1:0] root;
	} pcsd_cell_t;

endpackage

`default_nettype wire

// ===== rtl/pcsd_front.sv =====
// front end: channel differences, their squares and the scaled sum 4Q
// three pipeline stages; uses pcsd_pkg
`default_nettype none

module pcsd_front
	import pcsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [CHAN_W-1:0] chan_first,
	input  wire logic [CHAN_W-1:0] chan_second,
	input  wire logic [CHAN_W-1:0] chan_third,
	output logic                   out_vld,
	output pcsd_cell_t             out_data
);

	logic [DIFF_W-1:0] da, db, dc;
	logic [MAG_W-1:0]  ma_s1, mb_s1, mc_s1;
	logic [SQ_W-1:0]   sa_s2, sb_s2, sc_s2;
	logic [SUM_W-1:0]  sum;
	logic              vld_s1, vld_s2, vld_s3;
	pcsd_cell_t        data_s3;

	function automatic logic [DIFF_W-1:0] diff_of(
		input logic [CHAN_W-1:0] x,
		input logic [CHAN_W-1:0] y,
		input logic [CHAN_W-1:0] z
	);
		// s - 3x = y + z - 2x
		diff_of = DIFF_W'(y) + DIFF_W'(z) - (DIFF_W'(x) << 1);
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] m;
		m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
		mag_of = m[MAG_W-1:0];
	endfunction

	assign da = diff_of(chan_first, chan_second, chan_third);
	assign db = diff_of(chan_second, chan_first, chan_third);
	assign dc = diff_of(chan_third, chan_first, chan_second);

	assign sum = SUM_W'(sa_s2) + SUM_W'(sb_s2) + SUM_W'(sc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= mag_of(da);
			mb_s1 <= mag_of(db);
			mc_s1 <= mag_of(dc);
			sa_s2 <= ma_s1 * ma_s1;
			sb_s2 <= mb_s1 * mb_s1;
			sc_s2 <= mc_s1 * mc_s1;
			data_s3.q4   <= {sum[Q_W-1:0], 2'b00};
			data_s3.root <= '0;
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = data_s3;

endmodule

`default_nettype wire

// ===== rtl/pcsd_root_cell.sv =====
// one cell of the root search chain: decides one bit of the spread
// keeps the bit if 27*(2r-1)^2 <= 4Q holds for the trial value; uses pcsd_pkg
`default_nettype none

module pcsd_root_cell
	import pcsd_pkg::*;
#(
	parameter int unsigned BIT = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_vld,
	input  pcsd_cell_t      in_data,
	output logic            out_vld,
	output pcsd_cell_t      out_data
);

	logic [ROOT_W-1:0]  trial;
	logic [ODD_W-1:0]   odd;
	logic [ODDSQ_W-1:0] odd_sq;
	logic [Q4_W-1:0]    bound;
	logic               vld_q;
	pcsd_cell_t         data_q;

	assign trial  = in_data.root | (ROOT_W'(1) << BIT);
	assign odd    = {trial, 1'b0} - ODD_W'(1);
	assign odd_sq = odd * odd;
	// times 27 as 16 + 8 + 2 + 1
	assign bound  = (Q4_W'(odd_sq) << 4) + (Q4_W'(odd_sq) << 3)
	              + (Q4_W'(odd_sq) << 1) + Q4_W'(odd_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.q4   <= in_data.q4;
			data_q.root <= (bound <= in_data.q4) ? trial : in_data.root;
		end
	end

	assign out_vld  = vld_q;
	assign out_data = data_q;

endmodule

`default_nettype wire

// ===== rtl/pixel_channel_std_deviation_top.sv =====
// top level of the pixel channel spread block: stream ports, front end, root cells
// depends on pcsd_pkg, pcsd_front and pcsd_root_cell
`default_nettype none

// Takes one pixel of three 8-bit channels per transfer and returns the rounded
// population standard deviation of the channels (0..120), the saturation weight
// of exposure fusion. Throughput is one pixel per clock while results are taken.
// The pipeline has ten register stages: three form the differences, squares and
// 4Q, then a chain of seven cells decides the result one bit per cycle while the
// pipeline advances, most significant bit first. The whole pipeline holds while
// the output register carries a result that is not taken, and moves on otherwise.
module pixel_channel_std_deviation_top
	import pcsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // chan_first [7:0], chan_second [15:8], chan_third [23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // spread [6:0], zero [7]
);

	logic       en;
	logic       vld [ROOT_W+1];
	pcsd_cell_t data [ROOT_W+1];

	// advance while the output stage is empty or its transfer completes
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	pcsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (s_tvalid),
		.chan_first  (s_tdata[7:0]),
		.chan_second (s_tdata[15:8]),
		.chan_third  (s_tdata[23:16]),
		.out_vld     (vld[0]),
		.out_data    (data[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		pcsd_root_cell #(
			.BIT (ROOT_W - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld[i]),
			.in_data  (data[i]),
			.out_vld  (vld[i+1]),
			.out_data (data[i+1])
		);
	end

	assign m_tvalid = vld[ROOT_W];
	assign m_tdata  = {1'b0, data[ROOT_W].root};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for pixel_channel_std_deviation_top: random and corner pixels,
// exact integer predictor of the rounded channel spread, random stalls on both sides
// depends on pcsd_pkg and the rtl of the block
module tb_top;
	import pcsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAN_W-1:0] third;
		logic [CHAN_W-1:0] second;
		logic [CHAN_W-1:0] first;
	} pixel_t;

	localparam int unsigned N_RANDOM = 550;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	pixel_t            pixel_q[$];
	logic [ROOT_W-1:0] spread_q[$];
	int unsigned       mismatches = 0;
	int unsigned       pixels_sent = 0;
	int unsigned       send_wait = 0;
	int unsigned       send_calm = 0;
	int unsigned       recv_wait = 0;
	int unsigned       recv_calm = 0;
	logic              rx_hold = 1'b0;

	pixel_channel_std_deviation_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// rounded population std deviation: largest r with 27*(2r-1)^2 <= 4Q
	function automatic logic [ROOT_W-1:0] channel_spread(pixel_t px);
		int sum;
		int da;
		int db;
		int dc;
		int q4;
		int r;
		sum = px.first + px.second + px.third;
		da = sum - 3 * px.first;
		db = sum - 3 * px.second;
		dc = sum - 3 * px.third;
		q4 = 4 * (da * da + db * db + dc * dc);
		r = 0;
		for (int k = 1; k < (1 << ROOT_W); k++) begin
			if (27 * (2 * k - 1) * (2 * k - 1) <= q4)
				r = k;
		end
		return r[ROOT_W-1:0];
	endfunction

	function automatic pixel_t make_pixel(int a, int b, int c);
		pixel_t px;
		px.first = a[CHAN_W-1:0];
		px.second = b[CHAN_W-1:0];
		px.third = c[CHAN_W-1:0];
		return px;
	endfunction

	// pixel source: a random gap drawn per pixel, with runs of back-to-back transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				spread_q.push_back(channel_spread(pixel_t'(s_tdata)));
				pixels_sent <= pixels_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					s_tvalid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					s_tdata <= pixel_q.pop_front();
					s_tvalid <= 1'b1;
					if (send_calm != 0) begin
						send_calm <= send_calm - 1;
						send_wait <= 0;
					end else if ($urandom_range(0, 15) == 0) begin
						send_calm <= $urandom_range(10, 30);
						send_wait <= 0;
					end else begin
						send_wait <= $urandom_range(0, 3);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin : sink
		int unsigned stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (spread_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: unexpected result transfer, spread %0d", $realtime,
							m_tdata[ROOT_W-1:0]);
				end else if (m_tdata[ROOT_W-1:0] !== spread_q[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: spread expected %0d, got %0d", $realtime,
							spread_q[0], m_tdata[ROOT_W-1:0]);
					void'(spread_q.pop_front());
				end else begin
					void'(spread_q.pop_front());
				end
				if (recv_calm != 0) begin
					recv_calm <= recv_calm - 1;
					stall = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					recv_calm <= $urandom_range(10, 30);
					stall = 0;
				end else begin
					stall = $urandom_range(0, 3);
				end
				recv_wait <= stall;
				m_tready <= (stall == 0) && !rx_hold;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				m_tready <= (recv_wait == 1) && !rx_hold;
			end else begin
				m_tready <= !rx_hold;
			end
		end
	end

	// long back-pressure once the stream is running, so the pipeline fills and stalls its input
	initial begin
		while (pixels_sent < 200)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (64) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		// corners: flat pixels, largest spread, single-channel outliers, rounding threshold
		pixel_q.push_back(make_pixel(0, 0, 0));
		pixel_q.push_back(make_pixel(255, 255, 255));
		pixel_q.push_back(make_pixel(128, 128, 128));
		pixel_q.push_back(make_pixel(255, 255, 0));
		pixel_q.push_back(make_pixel(255, 0, 255));
		pixel_q.push_back(make_pixel(0, 255, 255));
		pixel_q.push_back(make_pixel(0, 0, 255));
		pixel_q.push_back(make_pixel(0, 255, 0));
		pixel_q.push_back(make_pixel(255, 0, 0));
		pixel_q.push_back(make_pixel(1, 0, 0));
		pixel_q.push_back(make_pixel(0, 1, 0));
		pixel_q.push_back(make_pixel(0, 0, 1));
		pixel_q.push_back(make_pixel(2, 0, 0));
		pixel_q.push_back(make_pixel(254, 255, 255));
		pixel_q.push_back(make_pixel(0, 128, 255));
		pixel_q.push_back(make_pixel(255, 127, 0));
		pixel_q.push_back(make_pixel(8'hAA, 8'h55, 8'hAA));
		pixel_q.push_back(make_pixel(8'h55, 8'hAA, 8'h55));
		pixel_q.push_back(make_pixel(100, 101, 99));
		pixel_q.push_back(make_pixel(3, 7, 11));
		for (int i = 0; i < N_RANDOM; i++) begin
			int a;
			int b;
			int c;
			a = $urandom_range(0, 255);
			case ($urandom_range(0, 5))
				0: begin
					// nearly gray pixel, small spreads near the rounding steps
					b = a + $urandom_range(0, 8) - 4;
					c = a + $urandom_range(0, 8) - 4;
					if (b < 0) b = 0;
					if (b > 255) b = 255;
					if (c < 0) c = 0;
					if (c > 255) c = 255;
				end
				1: begin
					a = $urandom_range(0, 1) * 255;
					b = $urandom_range(0, 1) * 255;
					c = $urandom_range(0, 1) * 255;
				end
				default: begin
					b = $urandom_range(0, 255);
					c = $urandom_range(0, 255);
				end
			endcase
			pixel_q.push_back(make_pixel(a, b, c));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_q.size() != 0 || s_tvalid || spread_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatches == 0 && spread_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
